[rtl/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer: opcodes,
// field widths and the command passed from the code table to the packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // fixed field widths
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int OPCODE_W = 2;

  // default parameter values
  localparam int DEF_MAX_CODE_LEN  = 32;
  localparam int DEF_ALPHABET_SIZE = 256;

  // item opcodes; the remaining code is ignored
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  // command from the table stage to the packer
  typedef struct packed {
    logic              valid;
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

[rtl/huffman_code_bit_packer.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder output stage: code table loaded by load beats, lookup stage
// and a bit packer; code bits go MSB first, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// An encode beat's bytes pass the lookup, accumulator and output registers.
// Throughput: one beat per cycle while each beat yields at most one byte and
//   the output is not stalled; an encode beat yielding more bytes holds off
//   the next beat until they are out (up to 4 bytes for a 32-bit code).
// Reset synchronously clears the accumulator, pending count and valid flags;
//   the code table is not cleared and each entry must be loaded before use.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN  = DEF_MAX_CODE_LEN,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic [CODE_W-1:0]   in_code_word,
  input  logic [LEN_W-1:0]    in_code_length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_last_in_run,
  output logic                out_is_final
);

  cmd_t cmd;
  logic take;

  // code table and lookup stage
  hcbp_table #(
    .MAX_CODE_LEN  (MAX_CODE_LEN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_table (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_symbol      (in_symbol),
    .in_code_word   (in_code_word),
    .in_code_length (in_code_length),
    .take           (take),
    .cmd            (cmd)
  );

  // bit accumulator and output register
  hcbp_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run),
    .out_is_final    (out_is_final)
  );

endmodule

[rtl/hcbp_table.sv]
// ----------------------------------------------------------------------------
// hcbp_table
// Code table memory and lookup stage. Load beats write a masked, saturated
// code entry; encode beats read the entry into a registered command.
// ----------------------------------------------------------------------------
module hcbp_table
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN  = DEF_MAX_CODE_LEN,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_word,
  input  logic [LEN_W-1:0]  in_code_length,
  input  logic              take,
  output cmd_t              cmd
);

  localparam int IDX_W   = $clog2(ALPHABET_SIZE);
  localparam int ENTRY_W = CODE_W + LEN_W;

  logic [ENTRY_W-1:0] mem [ALPHABET_SIZE];
  logic [ENTRY_W-1:0] rd_entry_r;
  logic               s1_valid_r;
  logic               s1_flush_r;

  logic               accept;
  logic               in_range;
  logic               is_load;
  logic               is_encode;
  logic               is_flush;
  logic               wr_en;
  logic               rd_en;
  logic [IDX_W-1:0]   addr;
  logic [LEN_W-1:0]   len_sat;
  logic [CODE_W-1:0]  code_mask;

  // beat decode
  always_comb begin
    accept    = in_valid && in_ready;
    in_range  = {1'b0, in_symbol} < (SYM_W + 1)'(ALPHABET_SIZE);
    is_load   = in_opcode == OP_LOAD;
    is_encode = in_opcode == OP_ENCODE;
    is_flush  = in_opcode == OP_FLUSH;
    wr_en     = accept && is_load && in_range;
    rd_en     = accept && is_encode && in_range;
    addr      = in_symbol[IDX_W-1:0];
  end

  // saturate the length and drop code bits above it
  always_comb begin
    if (in_code_length > LEN_W'(MAX_CODE_LEN)) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = in_code_length;
    end
    if (len_sat >= LEN_W'(CODE_W)) begin
      code_mask = '1;
    end else begin
      code_mask = ~({CODE_W{1'b1}} << len_sat);
    end
  end

  // code table, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {len_sat, in_code_word & code_mask};
    end
    if (rd_en) begin
      rd_entry_r <= mem[addr];
    end
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= (is_encode && in_range) || is_flush;
      s1_flush_r <= is_flush;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  // the stage frees up in the cycle the packer takes its command
  assign in_ready = !s1_valid_r || take;

  always_comb begin
    cmd.valid = s1_valid_r;
    cmd.flush = s1_flush_r;
    cmd.code  = rd_entry_r[CODE_W-1:0];
    cmd.len   = rd_entry_r[ENTRY_W-1:CODE_W];
  end

endmodule

[rtl/hcbp_packer.sv]
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and output register. Appends code bits, emits one byte per
// cycle MSB first unless stalled, pads the rest into a final byte on flush.
// ----------------------------------------------------------------------------
module hcbp_packer
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_in_run,
  output logic              out_is_final
);

  localparam int ACC_W  = MAX_CODE_LEN + BYTE_W - 1;
  localparam int PEND_W = $clog2(ACC_W + 1);
  localparam int SH_W   = $clog2(BYTE_W + 1);

  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [PEND_W-1:0] pend_r;
  logic [PEND_W-1:0] pend_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_final_r;

  logic              out_free;
  logic              have_byte;
  logic              emit;
  logic [PEND_W-1:0] pend_em;
  logic [ACC_W-1:0]  acc_keep;
  logic [PEND_W-1:0] pend_keep;
  logic              can_absorb;
  logic              take_enc;
  logic              take_flush;
  logic              final_byte;
  logic [SH_W-1:0]   pad_sh;

  // byte emission and the state left after it
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    have_byte  = pend_r >= PEND_W'(BYTE_W);
    emit       = have_byte && out_free;
    pend_em    = pend_r - PEND_W'(BYTE_W);
    acc_keep   = emit ? (acc_r & ~({ACC_W{1'b1}} << pend_em)) : acc_r;
    pend_keep  = emit ? pend_em : pend_r;
    can_absorb = pend_keep < PEND_W'(BYTE_W);
    take_enc   = cmd.valid && !cmd.flush && can_absorb;
    take_flush = cmd.valid && cmd.flush && !have_byte &&
                 ((pend_r == '0) || out_free);
    take       = take_enc || take_flush;
    final_byte = take_flush && (pend_r != '0);
    pad_sh     = SH_W'(BYTE_W) - SH_W'(pend_r);
  end

  // accumulator next state
  always_comb begin
    if (take_flush) begin
      acc_nxt  = '0;
      pend_nxt = '0;
    end else if (take_enc) begin
      acc_nxt  = (acc_keep << cmd.len) | ACC_W'(cmd.code);
      pend_nxt = pend_keep + PEND_W'(cmd.len);
    end else begin
      acc_nxt  = acc_keep;
      pend_nxt = pend_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit || final_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= BYTE_W'(acc_r >> pend_em);
      out_last_r  <= pend_em < PEND_W'(BYTE_W);
      out_final_r <= 1'b0;
    end else if (final_byte) begin
      out_byte_r  <= BYTE_W'(acc_r[BYTE_W-1:0] << pad_sh);
      out_last_r  <= 1'b1;
      out_final_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_in_run = out_last_r;
  assign out_is_final    = out_final_r;

  // pending count stays within the accumulator
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(ACC_W))
    else $error("pending bit count exceeds accumulator width");

  // bits above the pending count are always clear
  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> pend_r) == '0)
    else $error("stale accumulator bits above pending count");

  // a flush leaves nothing pending
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take_flush |=> (pend_r == '0) && (acc_r == '0))
    else $error("accumulator not cleared after flush");

  // a new code is only appended when less than a byte remains
  a_absorb_room: assert property (@(posedge clk) disable iff (!rst_n)
    take_enc |-> pend_keep < PEND_W'(BYTE_W))
    else $error("code appended with a whole byte still pending");

endmodule
